FILE: design/plu3_pkg.sv
`default_nettype none

package plu3_pkg;

    // Residue modulo three
    typedef logic [1:0] res3_t;

    localparam res3_t RES_ZERO = 2'd0;
    localparam res3_t RES_ONE  = 2'd1;
    localparam res3_t RES_TWO  = 2'd2;

    // Result sequence of one point: held point, one third, two thirds, new point
    typedef enum logic [3:0] {
        STEP_BASE  = 4'b0001,
        STEP_THIRD = 4'b0010,
        STEP_TWO   = 4'b0100,
        STEP_END   = 4'b1000
    } step_t;

endpackage

`default_nettype wire

FILE: design/plu3_if.sv
`default_nettype none

// Stroke point channel
interface plu3_point_if #(
    parameter int COORD_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic        [TIME_WIDTH-1:0]  stamp;
    logic                          final_point;

    modport source (output valid, pos_x, pos_y, stamp, final_point, input ready);
    modport sink   (input valid, pos_x, pos_y, stamp, final_point, output ready);
endinterface

// Upsampled point channel
interface plu3_result_if #(
    parameter int COORD_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic        [TIME_WIDTH-1:0]  out_stamp;
    logic                          run_last;

    modport source (output valid, out_x, out_y, out_stamp, run_last, input ready);
    modport sink   (input valid, out_x, out_y, out_stamp, run_last, output ready);
endinterface

// Configuration write channel (time enable)
interface plu3_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: design/plu3_div3.sv
`default_nettype none

// Unsigned division by three. The running remainder of long division is
// found for every bit at once: since 2 = -1 mod 3, the remainder of the
// bits above a position is a signed suffix sum of bits, taken by a
// log-depth scan of residue additions.
module plu3_div3
    import plu3_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0] dividend,
    output logic      [WIDTH-1:0] quotient,
    output res3_t                 remainder
);

    localparam int LVLS = $clog2(WIDTH);

    res3_t scan   [0:LVLS][0:WIDTH-1];
    res3_t rem_at [0:WIDTH];

    function automatic res3_t add_mod3(input res3_t a, input res3_t b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 3'd3) ? res3_t'(s - 3'd3) : res3_t'(s);
    endfunction

    function automatic res3_t neg_mod3(input res3_t a);
        res3_t n;
        case (a)
            RES_ONE: n = RES_TWO;
            RES_TWO: n = RES_ONE;
            default: n = RES_ZERO;
        endcase
        return n;
    endfunction

    always_comb
    begin
        // Seed: bit weight alternates between +1 and -1 modulo three
        for (int j = 0; j < WIDTH; j++)
        begin
            if (dividend[j])
                scan[0][j] = (j % 2 == 1) ? RES_TWO : RES_ONE;
            else
                scan[0][j] = RES_ZERO;
        end

        // Suffix scan towards the top bit
        for (int l = 0; l < LVLS; l++)
        begin
            for (int j = 0; j < WIDTH; j++)
            begin
                if (j + (1 << l) < WIDTH)
                    scan[l+1][j] = add_mod3(scan[l][j], scan[l][j + (1 << l)]);
                else
                    scan[l+1][j] = scan[l][j];
            end
        end

        // Remainder of the value above and including each bit
        rem_at[WIDTH] = RES_ZERO;
        for (int j = 0; j < WIDTH; j++)
        begin
            rem_at[j] = (j % 2 == 1) ? neg_mod3(scan[LVLS][j]) : scan[LVLS][j];
        end

        // Quotient bit set where 2*r + bit reaches three
        for (int j = 0; j < WIDTH; j++)
        begin
            quotient[j] = (rem_at[j+1] == RES_TWO) ||
                          ((rem_at[j+1] == RES_ONE) && dividend[j]);
        end

        remainder = rem_at[0];
    end

endmodule

`default_nettype wire

FILE: design/polyline_upsample_by_three.sv
`default_nettype none

// Linear upsampling of a pen stroke by three.
// points : stroke points (pos_x, pos_y, stamp, final_point), valid/ready.
// results: upsampled points (out_x, out_y, out_stamp, run_last), valid/ready.
// cfg    : one-bit time enable write, always ready; write only while idle.
// For each point after the first of a stroke the block emits the held point
// and the points one and two thirds of the way to the new one; a final point
// also emits itself and closes the stroke. run_last marks the last result of
// each point. A first point that is not final emits nothing.
// A point passes through the input register and the sequencing stage before
// its first result is in the result register. Throughput: one result per
// cycle while results is ready, set by the single result register. The
// division by three sits between the input register and the sequencing stage.
// A new point is taken while the result register still waits: when results
// stalls, the sequencer and then the input register hold and points.ready
// falls. Reset clears the held stroke and sets the time enable.
module polyline_upsample_by_three
    import plu3_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    plu3_point_if.sink     points,
    plu3_result_if.source  results,
    plu3_cfg_if.sink       cfg
);

    localparam int CW = COORD_WIDTH;
    localparam int TW = TIME_WIDTH;

    // Configuration
    logic time_en_reg;

    // Held point of the stroke
    logic          have_prev_reg;
    logic [CW-1:0] prev_x_reg;
    logic [CW-1:0] prev_y_reg;
    logic [TW-1:0] prev_t_reg;

    // Input register
    logic          a_valid_reg;
    logic          a_valid_next;
    logic          a_hp_reg;
    logic          a_fin_reg;
    logic [CW-1:0] a_x_reg;
    logic [CW-1:0] a_y_reg;
    logic [TW-1:0] a_t_reg;
    logic [CW-1:0] a_px_reg;
    logic [CW-1:0] a_py_reg;
    logic [TW-1:0] a_pt_reg;

    // Sequencing stage
    logic          b_valid_reg;
    logic          b_valid_next;
    step_t         step_reg;
    step_t         step_next;
    logic          b_fin_reg;
    logic [CW-1:0] b_x_base_reg;
    logic [CW-1:0] b_y_base_reg;
    logic [TW-1:0] b_t_base_reg;
    logic          b_x_neg_reg;
    logic          b_y_neg_reg;
    logic [CW-1:0] b_x_quo_reg;
    logic [CW-1:0] b_y_quo_reg;
    logic [TW-1:0] b_t_quo_reg;
    logic          b_x_r2_reg;
    logic          b_y_r2_reg;
    logic          b_t_r2_reg;
    logic [CW-1:0] b_x_end_reg;
    logic [CW-1:0] b_y_end_reg;
    logic [TW-1:0] b_t_end_reg;

    // Result register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [CW-1:0] out_x_reg;
    logic [CW-1:0] out_y_reg;
    logic [TW-1:0] out_t_reg;
    logic          out_last_reg;
    logic [CW-1:0] out_x_next;
    logic [CW-1:0] out_y_next;
    logic [TW-1:0] out_t_next;

    // Handshake control
    logic accept;
    logic a_to_b;
    logic b_free;
    logic b_done;
    logic b_has_res;
    logic is_last;
    logic out_free;
    logic emit;

    // Deltas and thirds
    logic [CW:0]   dx_fwd;
    logic [CW:0]   dx_bwd;
    logic [CW:0]   dy_fwd;
    logic [CW:0]   dy_bwd;
    logic          x_neg;
    logic          y_neg;
    logic [CW-1:0] x_mag;
    logic [CW-1:0] y_mag;
    logic [TW-1:0] t_mag;
    logic [CW-1:0] x_quo;
    logic [CW-1:0] y_quo;
    logic [TW-1:0] t_quo;
    res3_t         x_rem;
    res3_t         y_rem;
    res3_t         t_rem;

    // Offsets for the current step
    logic [CW:0]   part_x;
    logic [CW:0]   part_y;
    logic [TW:0]   part_t;
    logic [CW:0]   sum_x;
    logic [CW:0]   sum_y;
    logic [TW:0]   sum_t;

    // Configuration write
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_en_reg <= 1'b1;
        else if (cfg.valid)
            time_en_reg <= cfg.data;
    end

    // Flow control across the three stages
    assign out_free  = !out_valid_reg || results.ready;
    assign b_has_res = b_valid_reg && !((step_reg == STEP_END) && !b_fin_reg);
    assign is_last   = (step_reg == STEP_END) || ((step_reg == STEP_TWO) && !b_fin_reg);
    assign emit      = b_has_res && out_free;
    assign b_done    = b_valid_reg && (!b_has_res || (out_free && is_last));
    assign b_free    = !b_valid_reg || b_done;
    assign a_to_b    = a_valid_reg && b_free;
    assign points.ready = !a_valid_reg || a_to_b;
    assign accept    = points.valid && points.ready;

    assign a_valid_next   = accept ? 1'b1 : (a_to_b ? 1'b0 : a_valid_reg);
    assign b_valid_next   = a_to_b ? 1'b1 : (b_done ? 1'b0 : b_valid_reg);
    assign out_valid_next = emit ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    // Load the first step when a point enters; advance it on each result but the last
    always_comb
    begin
        step_next = step_reg;
        if (a_to_b)
            step_next = a_hp_reg ? STEP_BASE : STEP_END;
        else if (emit && !is_last)
        begin
            case (step_reg)
                STEP_BASE:  step_next = STEP_THIRD;
                STEP_THIRD: step_next = STEP_TWO;
                STEP_TWO:   step_next = STEP_END;
                default:    step_next = STEP_END;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            step_reg      <= STEP_END;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            if (accept)
                have_prev_reg <= !points.final_point;
        end
    end

    // Hold the latest point of the stroke
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_t_reg <= '0;
        end
        else if (accept)
        begin
            prev_x_reg <= points.pos_x;
            prev_y_reg <= points.pos_y;
            prev_t_reg <= points.stamp;
        end
    end

    // Capture the point with a snapshot of the held one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg    <= points.pos_x;
            a_y_reg    <= points.pos_y;
            a_t_reg    <= points.stamp;
            a_fin_reg  <= points.final_point;
            a_hp_reg   <= have_prev_reg;
            a_px_reg   <= prev_x_reg;
            a_py_reg   <= prev_y_reg;
            a_pt_reg   <= prev_t_reg;
        end
    end

    // Exact signed deltas as sign and magnitude; time delta wraps
    assign dx_fwd = {a_x_reg[CW-1], a_x_reg} - {a_px_reg[CW-1], a_px_reg};
    assign dx_bwd = {a_px_reg[CW-1], a_px_reg} - {a_x_reg[CW-1], a_x_reg};
    assign dy_fwd = {a_y_reg[CW-1], a_y_reg} - {a_py_reg[CW-1], a_py_reg};
    assign dy_bwd = {a_py_reg[CW-1], a_py_reg} - {a_y_reg[CW-1], a_y_reg};
    assign x_neg  = dx_fwd[CW];
    assign y_neg  = dy_fwd[CW];
    assign x_mag  = x_neg ? dx_bwd[CW-1:0] : dx_fwd[CW-1:0];
    assign y_mag  = y_neg ? dy_bwd[CW-1:0] : dy_fwd[CW-1:0];
    assign t_mag  = a_t_reg - a_pt_reg;

    plu3_div3 #(.WIDTH(CW)) u_div_x (
        .dividend  (x_mag),
        .quotient  (x_quo),
        .remainder (x_rem)
    );

    plu3_div3 #(.WIDTH(CW)) u_div_y (
        .dividend  (y_mag),
        .quotient  (y_quo),
        .remainder (y_rem)
    );

    plu3_div3 #(.WIDTH(TW)) u_div_t (
        .dividend  (t_mag),
        .quotient  (t_quo),
        .remainder (t_rem)
    );

    // Load the sequencing stage
    always_ff @(posedge clk)
    begin
        if (a_to_b)
        begin
            b_fin_reg    <= a_fin_reg;
            b_x_base_reg <= a_px_reg;
            b_y_base_reg <= a_py_reg;
            b_t_base_reg <= a_pt_reg;
            b_x_neg_reg  <= x_neg;
            b_y_neg_reg  <= y_neg;
            b_x_quo_reg  <= x_quo;
            b_y_quo_reg  <= y_quo;
            b_t_quo_reg  <= t_quo;
            b_x_r2_reg   <= (x_rem == RES_TWO);
            b_y_r2_reg   <= (y_rem == RES_TWO);
            b_t_r2_reg   <= (t_rem == RES_TWO);
            b_x_end_reg  <= a_x_reg;
            b_y_end_reg  <= a_y_reg;
            b_t_end_reg  <= a_t_reg;
        end
    end

    // Offset per step: zero, q, or 2q plus one where the remainder is two
    always_comb
    begin
        case (step_reg)
            STEP_THIRD:
            begin
                part_x = {1'b0, b_x_quo_reg};
                part_y = {1'b0, b_y_quo_reg};
                part_t = {1'b0, b_t_quo_reg};
            end
            STEP_TWO:
            begin
                part_x = {b_x_quo_reg, b_x_r2_reg};
                part_y = {b_y_quo_reg, b_y_r2_reg};
                part_t = {b_t_quo_reg, b_t_r2_reg};
            end
            default:
            begin
                part_x = '0;
                part_y = '0;
                part_t = '0;
            end
        endcase
    end

    assign sum_x = b_x_neg_reg ? ({b_x_base_reg[CW-1], b_x_base_reg} - part_x)
                               : ({b_x_base_reg[CW-1], b_x_base_reg} + part_x);
    assign sum_y = b_y_neg_reg ? ({b_y_base_reg[CW-1], b_y_base_reg} - part_y)
                               : ({b_y_base_reg[CW-1], b_y_base_reg} + part_y);
    assign sum_t = {1'b0, b_t_base_reg} + part_t;

    // Pick the new point on the closing step; drop the stamp when disabled
    assign out_x_next = (step_reg == STEP_END) ? b_x_end_reg : sum_x[CW-1:0];
    assign out_y_next = (step_reg == STEP_END) ? b_y_end_reg : sum_y[CW-1:0];
    assign out_t_next = !time_en_reg ? '0 :
                        ((step_reg == STEP_END) ? b_t_end_reg : sum_t[TW-1:0]);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_t_reg    <= out_t_next;
            out_last_reg <= is_last;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_x     = out_x_reg;
    assign results.out_y     = out_y_reg;
    assign results.out_stamp = out_t_reg;
    assign results.run_last  = out_last_reg;

    // The last result of a point always frees the sequencing stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_last) |-> b_done)
        else $error("last result emitted without releasing the sequencer");

    // A point is never taken over an input register that cannot drain
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!a_valid_reg || b_free))
        else $error("input register overwritten while occupied");

    // Division by three is exact: 3q + r rebuilds the magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (({1'b0, x_quo, 1'b0} + {2'b00, x_quo} + {{CW{1'b0}}, x_rem})
                         == {2'b00, x_mag}))
        else $error("x third does not match its delta");

    // A stalled result is never replaced by a fresh one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !emit)
        else $error("result register loaded while stalled");

endmodule

`default_nettype wire

FILE: test/polyline_upsample_by_three_tb.sv
`default_nettype none

module polyline_upsample_by_three_tb;

    localparam int CW = 32;
    localparam int TW = 32;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [TW-1:0]        STAMP_MAX = '1;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 100000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [TW-1:0]        stamp;
        logic                 final_point;
    } stroke_point_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [TW-1:0]        stamp;
        logic                 last;
    } upsampled_t;

    logic clk = 1'b0;
    logic rst_n;

    plu3_point_if  #(.COORD_WIDTH(CW), .TIME_WIDTH(TW)) points ();
    plu3_result_if #(.COORD_WIDTH(CW), .TIME_WIDTH(TW)) results ();
    plu3_cfg_if                                         cfg ();

    polyline_upsample_by_three #(
        .COORD_WIDTH(CW),
        .TIME_WIDTH (TW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points),
        .results(results),
        .cfg    (cfg)
    );

    // Points waiting to be offered, and upsampled points still owed by the block
    stroke_point_t pending_points[$];
    upsampled_t    expected_points[$];

    // Predictor copy of the held stroke and the time enable
    logic signed [CW-1:0] held_x      = '0;
    logic signed [CW-1:0] held_y      = '0;
    logic [TW-1:0]        held_stamp  = '0;
    logic                 stroke_open = 1'b0;
    logic                 time_on     = 1'b1;

    int send_idle_pct = 17;
    int recv_idle_pct = 68;
    bit pressure_on   = 1'b0;
    logic hold_off;
    int hold_count;
    int failures    = 0;
    int cycle_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // from + trunc(k * (to - from) / 3), difference taken without wrapping
    function automatic logic signed [CW-1:0] coord_third(input logic signed [CW-1:0] from,
                                                         input logic signed [CW-1:0] to,
                                                         input int k);
        longint span;
        longint sum;
        span = longint'(to) - longint'(from);
        sum  = longint'(from) + (k * span) / 3;
        return sum[CW-1:0];
    endfunction

    // from + floor(k * ((to - from) mod 2^TW) / 3), modulo 2^TW
    function automatic logic [TW-1:0] stamp_third(input logic [TW-1:0] from,
                                                  input logic [TW-1:0] to,
                                                  input int k);
        logic [TW-1:0] gap;
        logic [63:0]   part;
        gap  = to - from;
        part = (64'(gap) * 64'(k)) / 64'd3;
        return from + part[TW-1:0];
    endfunction

    // Work out the upsampled points that one accepted stroke point causes
    function automatic void upsample_point(input stroke_point_t p);
        upsampled_t r;
        if (stroke_open)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r.x     = coord_third(held_x, p.x, k);
                r.y     = coord_third(held_y, p.y, k);
                r.stamp = time_on ? stamp_third(held_stamp, p.stamp, k) : '0;
                r.last  = (k == 2) && !p.final_point;
                expected_points.push_back(r);
            end
        end
        if (p.final_point)
        begin
            r.x     = p.x;
            r.y     = p.y;
            r.stamp = time_on ? p.stamp : '0;
            r.last  = 1'b1;
            expected_points.push_back(r);
        end
        held_x      = p.x;
        held_y      = p.y;
        held_stamp  = p.stamp;
        stroke_open = !p.final_point;
    endfunction

    // Point driver: predict on each transaction, then offer the next point
    always @(posedge clk or negedge rst_n)
    begin : point_driver
        stroke_point_t nxt;
        if (!rst_n)
        begin
            points.valid       <= 1'b0;
            points.pos_x       <= '0;
            points.pos_y       <= '0;
            points.stamp       <= '0;
            points.final_point <= 1'b0;
        end
        else
        begin
            if (points.valid && points.ready)
            begin
                nxt.x           = points.pos_x;
                nxt.y           = points.pos_y;
                nxt.stamp       = points.stamp;
                nxt.final_point = points.final_point;
                upsample_point(nxt);
            end
            if (!points.valid || points.ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_points.pop_front();
                    points.valid       <= 1'b1;
                    points.pos_x       <= nxt.x;
                    points.pos_y       <= nxt.y;
                    points.stamp       <= nxt.stamp;
                    points.final_point <= nxt.final_point;
                end
                else
                begin
                    points.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, run once when pressure is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off   <= 1'b0;
            hold_count <= 0;
        end
        else if (pressure_on && hold_count < HOLD_CYCLES)
        begin
            hold_off   <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            hold_off <= 1'b0;
        end
    end

    // Result monitor: compare each transaction with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        upsampled_t want;
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result: out_x %0d out_y %0d out_stamp %0d run_last %0d",
                           results.out_x, results.out_y, results.out_stamp, results.run_last);
                    failures = failures + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (results.out_x !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, results.out_x);
                        failures = failures + 1;
                    end
                    if (results.out_y !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, results.out_y);
                        failures = failures + 1;
                    end
                    if (results.out_stamp !== want.stamp)
                    begin
                        $error("out_stamp: expected %0d, got %0d", want.stamp, results.out_stamp);
                        failures = failures + 1;
                    end
                    if (results.run_last !== want.last)
                    begin
                        $error("run_last: expected %0d, got %0d", want.last, results.run_last);
                        failures = failures + 1;
                    end
                end
            end
            results.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Abandon a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic [TW-1:0] stamp, input logic fin);
        stroke_point_t p;
        p.x           = x;
        p.y           = y;
        p.stamp       = stamp;
        p.final_point = fin;
        pending_points.push_back(p);
    endtask

    function automatic logic signed [CW-1:0] next_coord(input logic signed [CW-1:0] from);
        int step;
        logic signed [CW-1:0] c;
        step = int'($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(0, 9))
            0:       c = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            1, 2:    c = $urandom;
            default: c = from + step;
        endcase
        return c;
    endfunction

    function automatic logic [TW-1:0] next_stamp(input logic [TW-1:0] from);
        return ($urandom_range(0, 7) == 0) ? TW'($urandom) : from + $urandom_range(0, 50);
    endfunction

    // Queue random strokes; the last point stays open so the stroke spans the next write
    task automatic queue_random_strokes(input int count);
        stroke_point_t p;
        int left_in_stroke;
        left_in_stroke = 0;
        p.x     = '0;
        p.y     = '0;
        p.stamp = '0;
        for (int n = 0; n < count; n++)
        begin
            if (left_in_stroke == 0)
            begin
                left_in_stroke = $urandom_range(1, 7);
                p.x     = $urandom;
                p.y     = $urandom;
                p.stamp = $urandom;
            end
            else
            begin
                p.x     = next_coord(p.x);
                p.y     = next_coord(p.y);
                p.stamp = next_stamp(p.stamp);
            end
            left_in_stroke = left_in_stroke - 1;
            // cut the odd stroke short
            if ($urandom_range(0, 11) == 0)
                left_in_stroke = 0;
            p.final_point = (left_in_stroke == 0) && (n != count - 1);
            pending_points.push_back(p);
        end
    endtask

    // Hold until every point is taken and every result is back, then let the pipe settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_points.size() != 0 || points.valid || expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_time_enable(input logic on);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= on;
        do
            @(posedge clk);
        while (!cfg.ready);
        time_on = on;
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n              = 1'b0;
        cfg.valid          = 1'b0;
        cfg.data           = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Lone final point at the extremes
        add_point(COORD_MIN, COORD_MAX, '0, 1'b1);
        // Full-scale swings, stamp wrapping forwards and backwards
        add_point(COORD_MIN, COORD_MIN, STAMP_MAX, 1'b0);
        add_point(COORD_MAX, COORD_MAX, '0, 1'b0);
        add_point(COORD_MIN, COORD_MAX, STAMP_MAX, 1'b0);
        add_point(0, -1, 5, 1'b1);
        add_point(COORD_MAX, COORD_MIN, STAMP_MAX, 1'b1);
        // Small steps to exercise truncation towards zero
        add_point(0, 0, 0, 1'b0);
        add_point(1, -1, 1, 1'b0);
        add_point(2, -2, 2, 1'b0);
        add_point(-2, 2, 100, 1'b0);
        add_point(7, -7, 3, 1'b0);
        add_point(7, -7, 3, 1'b1);
        add_point(-1, 0, 32'h8000_0000, 1'b1);
        // Leave a stroke open across the time enable change
        add_point(100, -100, 10, 1'b0);
        add_point(-4, 5, 20, 1'b0);
        wait_idle();

        write_time_enable(1'b0);
        queue_random_strokes(40);
        wait_idle();

        // Swap idling and squeeze the block with a long receiver hold-off
        write_time_enable(1'b1);
        send_idle_pct = 68;
        recv_idle_pct = 17;
        pressure_on   = 1'b1;
        queue_random_strokes(40);
        wait_idle();

        write_time_enable(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_strokes(35);
        wait_idle();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
